### sv/mbdp_pkg.sv
package mbdp_pkg;

  // coordinate width of the ports and of the register halves
  localparam int CW = 16;
  // internal width: a half grown by the 12-bit margin, plus sign
  localparam int IW = CW + 2;
  localparam int MW = 12;
  localparam int AW = 5;

  typedef logic signed [IW-1:0] crd_t;

  typedef enum logic [2:0] {
    REG_BOX_X   = 3'd0,
    REG_BOX_Y   = 3'd1,
    REG_BOUND_X = 3'd2,
    REG_BOUND_Y = 3'd3,
    REG_MARGIN  = 3'd4,
    REG_FLAGS   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    HD_PLUS_Y  = 2'd0,
    HD_PLUS_X  = 2'd1,
    HD_MINUS_X = 2'd2,
    HD_MINUS_Y = 2'd3
  } heading_t;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] target_x;
    logic signed [CW-1:0] target_y;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] waypoint_x;
    logic signed [CW-1:0] waypoint_y;
    logic [1:0]           heading_code;
    logic                 path_found;
    logic                 last_waypoint;
  } out_t;

  // geometry derived from the registers
  typedef struct packed {
    crd_t fx_lo, fx_hi, fy_lo, fy_hi;   // field
    crd_t l, r, b, t;                   // grown box
    crd_t yt, yb, xl, xr;               // detour lines, clamped to field
    logic obst_on;
    logic bound_on;
  } geo_t;

  function automatic crd_t clampc(crd_t v, crd_t lo, crd_t hi);
    crd_t res;
    if (v < lo)      res = lo;
    else if (v > hi) res = hi;
    else             res = v;
    return res;
  endfunction

  function automatic logic in_field(crd_t x, crd_t y, geo_t g);
    return !g.bound_on ||
           (x >= g.fx_lo && x <= g.fx_hi && y >= g.fy_lo && y <= g.fy_hi);
  endfunction

  function automatic logic in_box(crd_t x, crd_t y, geo_t g);
    return x >= g.l && x <= g.r && y >= g.b && y <= g.t;
  endfunction

  // segment is fine: both ends in field, no contact with grown box
  function automatic logic seg_ok(crd_t ax, crd_t ay, crd_t bx, crd_t by, geo_t g);
    crd_t mxx, mnx, mxy, mny;
    logic hit;
    mxx = (ax > bx) ? ax : bx;
    mnx = (ax < bx) ? ax : bx;
    mxy = (ay > by) ? ay : by;
    mny = (ay < by) ? ay : by;
    hit = in_box(ax, ay, g) || in_box(bx, by, g);
    if (ay == by) begin
      if (ay >= g.b && ay <= g.t && mxx >= g.l && mnx <= g.r) hit = 1'b1;
    end else begin
      if (ax >= g.l && ax <= g.r && mxy >= g.b && mny <= g.t) hit = 1'b1;
    end
    return in_field(ax, ay, g) && in_field(bx, by, g) && !hit;
  endfunction

  function automatic logic [1:0] heading_of(crd_t ax, crd_t ay, crd_t bx, crd_t by);
    logic signed [IW:0] dx, dy;
    logic [IW:0] adx, ady;
    heading_t h;
    dx  = {bx[IW-1], bx} - {ax[IW-1], ax};
    dy  = {by[IW-1], by} - {ay[IW-1], ay};
    adx = dx[IW] ? (IW+1)'(-dx) : dx;
    ady = dy[IW] ? (IW+1)'(-dy) : dy;
    if (adx > ady) h = dx[IW] ? HD_MINUS_X : HD_PLUS_X;
    else           h = dy[IW] ? HD_MINUS_Y : HD_PLUS_Y;
    return h;
  endfunction

endpackage

### sv/mbdp_cfg.sv
module mbdp_cfg import mbdp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output geo_t          geo
);

  logic [31:0]   box_x_r, box_y_r, bnd_x_r, bnd_y_r;
  logic [MW-1:0] margin_r;
  logic [1:0]    flags_r;
  reg_idx_t      idx;
  logic          wr;
  crd_t          ex1, ex2, ey1, ey2, m;

  assign idx    = reg_idx_t'(paddr[AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r  <= 32'h1356_0FE8;
      box_y_r  <= 32'h10A1_0C30;
      bnd_x_r  <= 32'h13EC_0F50;
      bnd_y_r  <= 32'h1644_056E;
      margin_r <= '0;
      flags_r  <= 2'b11;
    end else if (wr) begin
      unique case (idx)
        REG_BOX_X:   box_x_r  <= pwdata;
        REG_BOX_Y:   box_y_r  <= pwdata;
        REG_BOUND_X: bnd_x_r  <= pwdata;
        REG_BOUND_Y: bnd_y_r  <= pwdata;
        REG_MARGIN:  margin_r <= pwdata[MW-1:0];
        REG_FLAGS:   flags_r  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BOX_X:   prdata = box_x_r;
      REG_BOX_Y:   prdata = box_y_r;
      REG_BOUND_X: prdata = bnd_x_r;
      REG_BOUND_Y: prdata = bnd_y_r;
      REG_MARGIN:  prdata = {{(32-MW){1'b0}}, margin_r};
      REG_FLAGS:   prdata = {30'd0, flags_r};
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    ex1 = IW'($signed(box_x_r[31:16]));
    ex2 = IW'($signed(box_x_r[15:0]));
    ey1 = IW'($signed(box_y_r[31:16]));
    ey2 = IW'($signed(box_y_r[15:0]));
    m   = crd_t'({1'b0, margin_r});
    geo.fx_lo    = IW'($signed(bnd_x_r[15:0]));
    geo.fx_hi    = IW'($signed(bnd_x_r[31:16]));
    geo.fy_lo    = IW'($signed(bnd_y_r[15:0]));
    geo.fy_hi    = IW'($signed(bnd_y_r[31:16]));
    geo.l        = ((ex1 < ex2) ? ex1 : ex2) - m;
    geo.r        = ((ex1 > ex2) ? ex1 : ex2) + m;
    geo.b        = ((ey1 < ey2) ? ey1 : ey2) - m;
    geo.t        = ((ey1 > ey2) ? ey1 : ey2) + m;
    geo.yt       = clampc(geo.t, geo.fy_lo, geo.fy_hi);
    geo.yb       = clampc(geo.b, geo.fy_lo, geo.fy_hi);
    geo.xl       = clampc(geo.l, geo.fx_lo, geo.fx_hi);
    geo.xr       = clampc(geo.r, geo.fx_lo, geo.fx_hi);
    geo.obst_on  = flags_r[0];
    geo.bound_on = flags_r[1];
  end

endmodule

### sv/manhattan_box_detour_planner_unit.sv
// pipeline: a request is registered in stage 1, then stage 2, then stage 3, which drives the output
// output: a two-segment path gives two waypoints, a detour three, a no-path result a single one,
//   emitted by the output stage one waypoint per cycle while out_stall is low;
//   stages 1 and 2 accept a new item every cycle unless the stall chain holds them
// reset: synchronous active-low rst_n clears all stage valids and loads register defaults
module manhattan_box_detour_planner_unit import mbdp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_t           in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_t          out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  geo_t geo;

  mbdp_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .geo
  );

  // stage 1: clamped points
  logic v1_r;
  crd_t sx1_r, sy1_r, tx1_r, ty1_r;
  // stage 2: points plus per-candidate pass flags
  logic v2_r;
  crd_t sx2_r, sy2_r, tx2_r, ty2_r;
  logic [5:0] ok2_r;
  // stage 3: planned waypoints, drained one per cycle while out_stall is low
  logic v3_r;
  crd_t wx_r [3];
  crd_t wy_r [3];
  logic [1:0] hd_r [3];
  logic [1:0] cnt_r, idx_r;
  logic found_r;

  logic en1, en2, en3, done3;

  // stall chain: a stage advances when the next one is empty or moving
  assign done3    = v3_r && !out_stall && (idx_r == cnt_r - 2'd1);
  assign en3      = !v3_r || done3;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // stage 1: clamp into field when bounds are on
  crd_t isx, isy, itx, ity;
  always_comb begin
    isx = IW'(in_data.start_x);
    isy = IW'(in_data.start_y);
    itx = IW'(in_data.target_x);
    ity = IW'(in_data.target_y);
    if (geo.bound_on) begin
      isx = clampc(isx, geo.fx_lo, geo.fx_hi);
      isy = clampc(isy, geo.fy_lo, geo.fy_hi);
      itx = clampc(itx, geo.fx_lo, geo.fx_hi);
      ity = clampc(ity, geo.fy_lo, geo.fy_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sx1_r <= isx;
      sy1_r <= isy;
      tx1_r <= itx;
      ty1_r <= ity;
    end
  end

  // stage 2: check all six candidates in parallel
  // order: x then y, y then x, over top, under bottom, left side, right side
  logic [5:0] ok_c;
  always_comb begin
    ok_c[0] = seg_ok(sx1_r, sy1_r, tx1_r, sy1_r, geo) &&
              seg_ok(tx1_r, sy1_r, tx1_r, ty1_r, geo);
    ok_c[1] = seg_ok(sx1_r, sy1_r, sx1_r, ty1_r, geo) &&
              seg_ok(sx1_r, ty1_r, tx1_r, ty1_r, geo);
    ok_c[2] = seg_ok(sx1_r, sy1_r, sx1_r, geo.yt, geo) &&
              seg_ok(sx1_r, geo.yt, tx1_r, geo.yt, geo) &&
              seg_ok(tx1_r, geo.yt, tx1_r, ty1_r, geo);
    ok_c[3] = seg_ok(sx1_r, sy1_r, sx1_r, geo.yb, geo) &&
              seg_ok(sx1_r, geo.yb, tx1_r, geo.yb, geo) &&
              seg_ok(tx1_r, geo.yb, tx1_r, ty1_r, geo);
    ok_c[4] = seg_ok(sx1_r, sy1_r, geo.xl, sy1_r, geo) &&
              seg_ok(geo.xl, sy1_r, geo.xl, ty1_r, geo) &&
              seg_ok(geo.xl, ty1_r, tx1_r, ty1_r, geo);
    ok_c[5] = seg_ok(sx1_r, sy1_r, geo.xr, sy1_r, geo) &&
              seg_ok(geo.xr, sy1_r, geo.xr, ty1_r, geo) &&
              seg_ok(geo.xr, ty1_r, tx1_r, ty1_r, geo);
    // obstacle off: direct path taken unchecked
    if (!geo.obst_on) ok_c[0] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sx2_r <= sx1_r;
      sy2_r <= sy1_r;
      tx2_r <= tx1_r;
      ty2_r <= ty1_r;
      ok2_r <= ok_c;
    end
  end

  // stage 3 input: pick the first passing candidate, build its segments
  crd_t px [4];
  crd_t py [4];
  logic [1:0] n_c;
  logic found_c;
  always_comb begin
    found_c = 1'b1;
    n_c     = 2'd2;
    for (int i = 0; i < 4; i++) begin
      px[i] = '0;
      py[i] = '0;
    end
    px[0] = sx2_r;
    py[0] = sy2_r;
    priority if (ok2_r[0]) begin
      px[1] = tx2_r;  py[1] = sy2_r;
      px[2] = tx2_r;  py[2] = ty2_r;
    end else if (ok2_r[1]) begin
      px[1] = sx2_r;  py[1] = ty2_r;
      px[2] = tx2_r;  py[2] = ty2_r;
    end else if (ok2_r[2] || ok2_r[3]) begin
      n_c   = 2'd3;
      px[1] = sx2_r;  py[1] = ok2_r[2] ? geo.yt : geo.yb;
      px[2] = tx2_r;  py[2] = py[1];
      px[3] = tx2_r;  py[3] = ty2_r;
    end else if (ok2_r[4] || ok2_r[5]) begin
      n_c   = 2'd3;
      px[1] = ok2_r[4] ? geo.xl : geo.xr;  py[1] = sy2_r;
      px[2] = px[1];  py[2] = ty2_r;
      px[3] = tx2_r;  py[3] = ty2_r;
    end else begin
      // no path: one all-zero failure result
      found_c = 1'b0;
      n_c     = 2'd1;
      px[0]   = '0;
      py[0]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r  <= 1'b0;
      idx_r <= '0;
    end else if (en3) begin
      v3_r  <= v2_r;
      idx_r <= '0;
    end else if (v3_r && !out_stall) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      cnt_r   <= n_c;
      found_r <= found_c;
      for (int i = 0; i < 3; i++) begin
        wx_r[i] <= px[i+1];
        wy_r[i] <= py[i+1];
        hd_r[i] <= found_c ? heading_of(px[i], py[i], px[i+1], py[i+1]) : HD_PLUS_Y;
      end
    end
  end

  assign out_valid              = v3_r;
  assign out_data.waypoint_x    = wx_r[idx_r][CW-1:0];
  assign out_data.waypoint_y    = wy_r[idx_r][CW-1:0];
  assign out_data.heading_code  = hd_r[idx_r];
  assign out_data.path_found    = found_r;
  assign out_data.last_waypoint = (idx_r == cnt_r - 2'd1);

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (idx_r < cnt_r)) else $error("waypoint index past plan length");

  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !found_r) |-> (cnt_r == 2'd1)) else $error("failure plan not single");

  a_plan_restart: assert property (@(posedge clk) disable iff (!rst_n)
    done3 |=> (idx_r == 2'd0)) else $error("next plan not started at first waypoint");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !en1) |=> (v1_r && $stable(sx1_r) && $stable(ty1_r)))
    else $error("stage 1 item lost under stall");

endmodule

### test/manhattan_box_detour_planner_unit_tb.sv
`timescale 1ns / 1ps
module manhattan_box_detour_planner_unit_tb;
  import mbdp_pkg::*;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  in_t           in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  out_t          out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  manhattan_box_detour_planner_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the planner registers
  logic [31:0] box_x_reg, box_y_reg, fld_x_reg, fld_y_reg;
  logic [11:0] margin_reg;
  logic [1:0]  flags_reg;

  out_t waypoint_q[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_off = 1'b0;
  bit   sending = 1'b0;

  // geometry in plain ints: halves are 16 bit, margin 12 bit, no overflow
  function automatic int sx16(logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit in_fld(int x, int y);
    if (!flags_reg[1]) return 1'b1;
    return x >= sx16(fld_x_reg[15:0]) && x <= sx16(fld_x_reg[31:16]) &&
           y >= sx16(fld_y_reg[15:0]) && y <= sx16(fld_y_reg[31:16]);
  endfunction

  // segment ends in field and clear of the grown box
  function automatic bit leg_clear(int ax, int ay, int bx, int by);
    int m, l, r, b, t, e1, e2;
    bit hit;
    m  = int'(margin_reg);
    e1 = sx16(box_x_reg[31:16]); e2 = sx16(box_x_reg[15:0]);
    l  = ((e1 < e2) ? e1 : e2) - m;  r = ((e1 > e2) ? e1 : e2) + m;
    e1 = sx16(box_y_reg[31:16]); e2 = sx16(box_y_reg[15:0]);
    b  = ((e1 < e2) ? e1 : e2) - m;  t = ((e1 > e2) ? e1 : e2) + m;
    hit = (ax >= l && ax <= r && ay >= b && ay <= t) ||
          (bx >= l && bx <= r && by >= b && by <= t);
    // horizontal when the y values match, else vertical at first x
    if (ay == by)
      hit |= ay >= b && ay <= t && ((ax > bx) ? ax : bx) >= l && ((ax < bx) ? ax : bx) <= r;
    else
      hit |= ax >= l && ax <= r && ((ay > by) ? ay : by) >= b && ((ay < by) ? ay : by) <= t;
    return in_fld(ax, ay) && in_fld(bx, by) && !hit;
  endfunction

  function automatic heading_t leg_heading(int ax, int ay, int bx, int by);
    int dx, dy;
    dx = bx - ax; dy = by - ay;
    if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy))
      return (dx >= 0) ? HD_PLUS_X : HD_MINUS_X;
    return (dy >= 0) ? HD_PLUS_Y : HD_MINUS_Y;
  endfunction

  // plans the route (direct, detour or no path) and queues its waypoints
  task automatic plan_route(in_t req);
    int sx, sy, tx, ty, xlo, xhi, ylo, yhi, m, e1, e2, k, n, i;
    int px[4], py[4];
    int yt, yb, xl, xr;
    out_t w;
    sx = req.start_x; sy = req.start_y; tx = req.target_x; ty = req.target_y;
    xlo = sx16(fld_x_reg[15:0]); xhi = sx16(fld_x_reg[31:16]);
    ylo = sx16(fld_y_reg[15:0]); yhi = sx16(fld_y_reg[31:16]);
    m = int'(margin_reg);
    if (flags_reg[1]) begin
      sx = clip(sx, xlo, xhi); sy = clip(sy, ylo, yhi);
      tx = clip(tx, xlo, xhi); ty = clip(ty, ylo, yhi);
    end
    n = 0;
    px[0] = sx; py[0] = sy;
    // x then y
    px[1] = tx; py[1] = sy; px[2] = tx; py[2] = ty;
    if (!flags_reg[0] || (leg_clear(sx, sy, tx, sy) && leg_clear(tx, sy, tx, ty))) n = 2;
    if (n == 0) begin
      // y then x
      px[1] = sx; py[1] = ty; px[2] = tx; py[2] = ty;
      if (leg_clear(sx, sy, sx, ty) && leg_clear(sx, ty, tx, ty)) n = 2;
    end
    if (n == 0) begin
      e1 = sx16(box_y_reg[31:16]); e2 = sx16(box_y_reg[15:0]);
      yt = clip(((e1 > e2) ? e1 : e2) + m, ylo, yhi);
      yb = clip(((e1 < e2) ? e1 : e2) - m, ylo, yhi);
      e1 = sx16(box_x_reg[31:16]); e2 = sx16(box_x_reg[15:0]);
      xl = clip(((e1 < e2) ? e1 : e2) - m, xlo, xhi);
      xr = clip(((e1 > e2) ? e1 : e2) + m, xlo, xhi);
      // over the top, bottom, left, right
      for (k = 0; k < 4 && n == 0; k++) begin
        if (k < 2) begin
          px[1] = sx; py[1] = (k == 0) ? yt : yb;
          px[2] = tx; py[2] = py[1];
        end else begin
          px[1] = (k == 2) ? xl : xr; py[1] = sy;
          px[2] = px[1]; py[2] = ty;
        end
        px[3] = tx; py[3] = ty;
        if (leg_clear(px[0], py[0], px[1], py[1]) && leg_clear(px[1], py[1], px[2], py[2]) &&
            leg_clear(px[2], py[2], px[3], py[3])) n = 3;
      end
    end
    if (n == 0) begin
      w = '0;
      w.last_waypoint = 1'b1;
      waypoint_q.push_back(w);
    end
    for (i = 1; i <= n; i++) begin
      w.waypoint_x    = px[i][15:0];
      w.waypoint_y    = py[i][15:0];
      w.heading_code  = leg_heading(px[i-1], py[i-1], px[i], py[i]);
      w.path_found    = 1'b1;
      w.last_waypoint = (i == n);
      waypoint_q.push_back(w);
    end
  endtask

  // register write: setup then access, driven on falling edges
  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AW'({idx, 2'b00}); pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BOX_X:   box_x_reg  = value;
      REG_BOX_Y:   box_y_reg  = value;
      REG_BOUND_X: fld_x_reg  = value;
      REG_BOUND_Y: fld_y_reg  = value;
      REG_MARGIN:  margin_reg = value[11:0];
      default:     flags_reg  = value[1:0];
    endcase
  endtask

  task automatic load_setup(logic [31:0] bx, logic [31:0] by, logic [31:0] fx,
                            logic [31:0] fy, logic [11:0] mg, logic [1:0] fl);
    reg_write(REG_BOX_X, bx);
    reg_write(REG_BOX_Y, by);
    reg_write(REG_BOUND_X, fx);
    reg_write(REG_BOUND_Y, fy);
    reg_write(REG_MARGIN, {20'd0, mg});
    reg_write(REG_FLAGS, {30'd0, fl});
  endtask

  // one request; predicted at acceptance
  task automatic send_request(in_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    plan_route(req);
  endtask

  task automatic drain_results();
    while (waypoint_q.size() != 0) @(posedge clk);
    // the block holds no hidden work once the last waypoint is out
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_coord(int lo, int hi);
    int v;
    case ($urandom_range(9))
      0: v = -32768;
      1: v = 32767;
      2: v = $urandom_range(65535) - 32768;
      default: v = lo + int'($urandom_range(hi - lo));
    endcase
    return v[15:0];
  endfunction

  // near the field, so most requests see the box
  task automatic random_burst(int count, int lo, int hi);
    in_t req;
    repeat (count) begin
      req.start_x  = rnd_coord(lo, hi);
      req.start_y  = rnd_coord(lo, hi);
      req.target_x = rnd_coord(lo, hi);
      req.target_y = rnd_coord(lo, hi);
      send_request(req);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // result checker; stall driven on the falling edge
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (waypoint_q.size() == 0) begin
        $error("unexpected waypoint %p", out_data);
        errors++;
      end else begin
        want = waypoint_q.pop_front();
        if (out_data.waypoint_x !== want.waypoint_x) begin
          $error("waypoint_x expected %0d got %0d", want.waypoint_x, out_data.waypoint_x);
          errors++;
        end
        if (out_data.waypoint_y !== want.waypoint_y) begin
          $error("waypoint_y expected %0d got %0d", want.waypoint_y, out_data.waypoint_y);
          errors++;
        end
        if (out_data.heading_code !== want.heading_code) begin
          $error("heading_code expected %0d got %0d", want.heading_code,
                 out_data.heading_code);
          errors++;
        end
        if (out_data.path_found !== want.path_found) begin
          $error("path_found expected %0b got %0b", want.path_found, out_data.path_found);
          errors++;
        end
        if (out_data.last_waypoint !== want.last_waypoint) begin
          $error("last_waypoint expected %0b got %0b", want.last_waypoint,
                 out_data.last_waypoint);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake and no register access
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps pushing
  initial begin
    wait (sending);
    repeat (40) @(negedge clk);
    hold_off = 1'b1;
    repeat (150) @(negedge clk);
    hold_off = 1'b0;
  end

  // directed requests: ok flag marks rows whose first waypoint is typed in
  typedef struct {
    in_t  req;
    bit   ok;
    out_t first;
  } row_t;

  row_t rows[$];

  task automatic add_row(int sx, int sy, int tx, int ty, bit ok = 0, out_t first = '0);
    row_t r;
    r.req.start_x = sx[15:0]; r.req.start_y = sy[15:0];
    r.req.target_x = tx[15:0]; r.req.target_y = ty[15:0];
    r.ok = ok; r.first = first;
    rows.push_back(r);
  endtask

  initial begin
    box_x_reg = 32'd324407272; box_y_reg = 32'd278989872;
    fld_x_reg = 32'd334237520; fld_y_reg = 32'd373556590;
    margin_reg = '0; flags_reg = 2'd3;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults after reset: box 4072..4950 x 3120..4257, field 3920..5100 x 1390..5700
    add_row(-32768, -32768, 32767, 32767);         // both clamped to field corners
    add_row(32767, 32767, -32768, -32768);
    add_row(4000, 2000, 5000, 2000, 1, '{16'sd5000, 16'sd2000, HD_PLUS_X, 1'b1, 1'b0});
    add_row(4500, 2000, 4500, 5500);               // straight through the box: no path, every detour touches the box
    add_row(4500, 5500, 4500, 2000);
    add_row(4000, 3500, 5050, 3500);               // left to right across
    add_row(4500, 3500, 4600, 3600);               // start inside the box: no path
    add_row(4000, 2000, 4000, 2000);               // zero length legs
    add_row(3920, 1390, 5100, 5700);
    foreach (rows[i]) begin
      send_request(rows[i].req);
      if (rows[i].ok && waypoint_q.size() != 0 &&
          waypoint_q[$ - (waypoint_q[$].path_found ? 1 : 0)] !== rows[i].first) begin
        $error("directed row %0d first waypoint expected %p", i, rows[i].first);
        errors++;
      end
    end
    @(negedge clk); in_valid <= 1'b0;
    drain_results();

    // obstacle off: plain x then y
    load_setup(32'h0100_FF00, 32'h0100_FF00, 32'h7FFF_8000, 32'h7FFF_8000, 12'd0, 2'd2);
    rows.delete();
    add_row(-32768, 0, 32767, 0);
    add_row(0, -32768, 0, 32767);
    add_row(0, 0, 0, 0);
    foreach (rows[i]) send_request(rows[i].req);
    @(negedge clk); in_valid <= 1'b0;
    drain_results();

    // no bounds, max margin, full range field so detour lines clamp to its edges
    load_setup(32'h8000_7FFF, 32'h7FFF_8000, 32'h7FFF_8000, 32'h7FFF_8000, 12'hFFF, 2'd1);
    rows.delete();
    add_row(-32768, -32768, 32767, 32767, 1, '{16'sd0, 16'sd0, HD_PLUS_Y, 1'b0, 1'b1});
    add_row(0, 0, 100, 100);
    foreach (rows[i]) send_request(rows[i].req);
    @(negedge clk); in_valid <= 1'b0;
    drain_results();

    // reversed field: every checked path fails
    load_setup(32'h0010_0020, 32'h0020_0010, 32'h0000_0064, 32'h0064_0000, 12'd5, 2'd3);
    rows.delete();
    add_row(1, 1, 50, 50, 1, '{16'sd0, 16'sd0, HD_PLUS_Y, 1'b0, 1'b1});
    foreach (rows[i]) send_request(rows[i].req);
    @(negedge clk); in_valid <= 1'b0;
    drain_results();

    // random phases with idling patterns and several setups
    sending = 1'b1;
    send_idle_pct = 35; recv_idle_pct = 61;
    load_setup(32'd324407272, 32'd278989872, 32'd334237520, 32'd373556590, 12'd0, 2'd3);
    random_burst(60, 1300, 5800);
    drain_results();

    send_idle_pct = 61; recv_idle_pct = 35;
    load_setup(32'hFFCE_0032, 32'h0032_FFCE, 32'h00C8_FF38, 32'h00C8_FF38,
               12'($urandom_range(40)), 2'd3);
    random_burst(60, -220, 220);
    drain_results();

    send_idle_pct = 0; recv_idle_pct = 0;
    load_setup($urandom, $urandom, 32'h03E8_FC18, 32'h03E8_FC18,
               12'($urandom_range(4095)), 2'($urandom_range(3)));
    random_burst(30, -1100, 1100);
    drain_results();
    load_setup(32'h0064_FF9C, 32'hFF9C_0064, 32'h01F4_FE0C, 32'h01F4_FE0C, 12'd10, 2'd1);
    random_burst(30, -600, 600);
    drain_results();

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
